@@ hdl/adq_pkg.sv @@
// ---------------------------------------------------------------------------
// adq_pkg
// Shared types and constants for the array deque: operation and status
// codes, controller states and the controller/datapath command bundles.
// ---------------------------------------------------------------------------
package adq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 2'd0,
    ST_REAR_FULL     = 2'd1,
    ST_NO_FRONT_ROOM = 2'd2,
    ST_EMPTY         = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_READ = 2'd2,
    S_OUT  = 2'd3
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture the accepted operation
    logic exec;     // apply the operation to the indices and the slots
    logic capture;  // take the popped word from the slot memory
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop_ok;   // held operation is a pop that will read a slot
  } dp_sts_t;

endpackage

@@ hdl/adq_ram.sv @@
// ---------------------------------------------------------------------------
// adq_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module adq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/adq_ctrl.sv @@
// ---------------------------------------------------------------------------
// adq_ctrl
// Sequencing FSM: accept one operation, execute it, wait for the slot read
// on a pop that reads a slot, then present the result until it is transferred.
// ---------------------------------------------------------------------------
module adq_ctrl
  import adq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.load    = 1'b0;
    cmd.exec    = 1'b0;
    cmd.capture = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.pop_ok ? S_READ : S_OUT;
      end
      S_READ: begin
        cmd.capture = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/adq_dp.sv @@
// ---------------------------------------------------------------------------
// adq_dp
// Deque datapath: head/tail indices, empty flag, slot memory and the
// result register.
// ---------------------------------------------------------------------------
module adq_dp
  import adq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  output dp_sts_t                    sts,
  input  logic [OP_W-1:0]            in_operation,
  input  logic signed [WORD_W-1:0]   in_value_in,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [WORD_W-1:0]   out_value_out,
  output logic                       out_now_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  op_t                 op_r;
  logic [WORD_W-1:0]   word_r;
  logic [AW-1:0]       head_r, head_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic                empty_r, empty_nxt;
  status_t             status_r, status_nxt;
  logic [WORD_W-1:0]   value_r;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_addr;
  logic [WORD_W-1:0]   ram_rdata;

  assign sts.pop_ok = !empty_r && (op_r == OP_POP_FRONT || op_r == OP_POP_REAR);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    empty_nxt  = empty_r;
    status_nxt = ST_OK;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = head_r;
    case (op_r)
      OP_PUSH_REAR: begin
        if (empty_r) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b0;
          ram_we    = 1'b1;
          ram_addr  = '0;
        end else if (tail_r == LAST_IDX) begin
          status_nxt = ST_REAR_FULL;
        end else begin
          tail_nxt = tail_r + 1'b1;
          ram_we   = 1'b1;
          ram_addr = tail_r + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (empty_r || head_r == '0) begin
          status_nxt = ST_NO_FRONT_ROOM;
        end else begin
          head_nxt = head_r - 1'b1;
          ram_we   = 1'b1;
          ram_addr = head_r - 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty_r) begin
          status_nxt = ST_EMPTY;
        end else begin
          ram_re   = 1'b1;
          ram_addr = head_r;
          if (head_r >= tail_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b1;
          end else begin
            head_nxt = head_r + 1'b1;
          end
        end
      end
      OP_POP_REAR: begin
        if (empty_r) begin
          status_nxt = ST_EMPTY;
        end else begin
          ram_re   = 1'b1;
          ram_addr = tail_r;
          if (tail_r <= head_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b1;
          end else begin
            tail_nxt = tail_r - 1'b1;
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    // gate memory access to the execute cycle
    ram_we = ram_we & cmd.exec;
    ram_re = ram_re & cmd.exec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_operation);
      word_r <= in_value_in;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      value_r  <= '0;
    end else if (cmd.capture) begin
      value_r <= ram_rdata;
    end
  end

  adq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (word_r),
    .rdata (ram_rdata)
  );

  assign out_status    = status_r;
  assign out_value_out = value_r;
  assign out_now_empty = empty_r;

endmodule

@@ hdl/array_double_ended_queue.sv @@
// Sequence: a push or a failed operation shows its result after the execute
//   state; a successful pop also passes the read state for the slot RAM read.
// Throughput: one operation at a time; a new input is taken only after the
//   result is transferred, as set by the accept/execute/read/output sequence.
// Reset (rst_n low, synchronous): deque empty, both indices zero, no result
//   pending; slot contents are left as they are.
// ---------------------------------------------------------------------------
// array_double_ended_queue
// Linear (non-circular) array deque of signed words with push and pop at
// both ends, one status result per operation.
// ---------------------------------------------------------------------------
module array_double_ended_queue
  import adq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_operation,
  input  logic signed [WORD_W-1:0] in_value_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [WORD_W-1:0] out_value_out,
  output logic                     out_now_empty
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Controller: one operation in flight; the result register holds the
  // outcome until the output transfer completes.
  adq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: indices, empty flag, slot RAM and result register. Words sit
  // in the contiguous slots head..tail; a push at the rear into an empty
  // deque restarts at slot 0, and popping the last word rewinds both
  // indices to zero.
  adq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_operation  (in_operation),
    .in_value_in   (in_value_in),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .out_now_empty (out_now_empty)
  );

endmodule

@@ hdl/adq_checker.sv @@
// ---------------------------------------------------------------------------
// adq_checker
// Port-level checks for the array deque, bound to the top level.
// ---------------------------------------------------------------------------
module adq_checker
  import adq_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [STATUS_W-1:0]      out_status,
  input logic signed [WORD_W-1:0] out_value_out,
  input logic                     out_now_empty
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_value_out) && $stable(out_now_empty))
    else $error("stalled result changed");

  // one operation at a time: no input transfer while a result is shown
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid)
    else $error("input taken while result pending");

  // failed operations return zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_value_out == '0)
    else $error("non-zero word on failed operation");

  // pop from empty leaves it empty; rear full means words are held
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY || out_status == ST_REAR_FULL)
      |-> out_now_empty == (out_status == ST_EMPTY))
    else $error("empty flag inconsistent with status");

endmodule

bind array_double_ended_queue adq_checker u_adq_checker (.*);
